// ===== hw/rtl/slcan_pkg.sv =====
// Shared types and character codes for the serial-line CAN frame parser.
`default_nettype none

package slcan_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ACK   = 8'h7A;
  localparam logic [7:0] CH_FRAME = 8'h74;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_UPA   = 8'h41;

  localparam int unsigned PosW   = 5;
  localparam logic [PosW-1:0] POS_MAX = 5'd31;

  localparam int unsigned IdentW  = 12;
  localparam int unsigned LengthW = 4;
  localparam int unsigned FrameDataW = 64;

  typedef enum logic [1:0] {
    KIND_UNDECIDED = 2'd0,
    KIND_FRAME     = 2'd1,
    KIND_DISCARD   = 2'd2
  } line_kind_e;

  typedef struct packed {
    logic [FrameDataW-1:0] data;
    logic [LengthW-1:0]    length;
    logic [IdentW-1:0]     ident;
  } frame_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slcan_line_acc.sv =====
// Per-line accumulator: absorbs one character per beat, reports a frame at carriage return.
`default_nettype none

module slcan_line_acc #(
  parameter int unsigned MAX_DATA_BYTES = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire logic [7:0]      char_i,
  output slcan_pkg::frame_t    frame_o,
  output logic                 frame_done_o
);
  import slcan_pkg::*;

  localparam int unsigned DataW = 8 * MAX_DATA_BYTES;
  localparam int unsigned NumNib = 2 * MAX_DATA_BYTES;
  localparam logic [PosW:0] DataEnd = (PosW+1)'(5 + NumNib);

  logic [PosW-1:0]    pos_q, pos_d;
  line_kind_e         kind_q, kind_d;
  logic [IdentW-1:0]  ident_q, ident_d;
  logic [LengthW-1:0] length_q, length_d;
  logic [DataW-1:0]   data_q, data_d;

  logic [3:0]      digit;
  logic [PosW-1:0] nib_k;
  logic            in_data;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= CH_DIG0 && c <= CH_DIG0 + 8'd9) begin
      t = c - CH_DIG0;
    end else if (c >= CH_LOWA && c <= CH_LOWA + 8'd5) begin
      t = c - CH_LOWA + 8'd10;
    end else if (c >= CH_UPA && c <= CH_UPA + 8'd5) begin
      t = c - CH_UPA + 8'd10;
    end
    return t[3:0];
  endfunction

  assign digit   = hex_value(char_i);
  assign nib_k   = pos_q - PosW'(5);
  assign in_data = ({1'b0, pos_q} >= (PosW+1)'(5)) && ({1'b0, pos_q} < DataEnd);

  always_comb begin
    pos_d        = pos_q;
    kind_d       = kind_q;
    ident_d      = ident_q;
    length_d     = length_q;
    data_d       = data_q;
    frame_done_o = 1'b0;
    if (take_i) begin
      if (char_i == CH_CR) begin
        frame_done_o = (kind_q == KIND_FRAME);
        pos_d        = '0;
        kind_d       = KIND_UNDECIDED;
        ident_d      = '0;
        length_d     = '0;
        data_d       = '0;
      end else begin
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + PosW'(1);
        end
        if (char_i == CH_ACK) begin
          kind_d = KIND_DISCARD;
        end else begin
          case (kind_q)
            KIND_UNDECIDED: begin
              kind_d = (pos_q == '0 && char_i == CH_FRAME) ? KIND_FRAME : KIND_DISCARD;
            end
            KIND_FRAME: begin
              if (pos_q >= PosW'(1) && pos_q <= PosW'(3)) begin
                ident_d = {ident_q[IdentW-5:0], digit};
              end else if (pos_q == PosW'(4)) begin
                length_d = digit;
              end else if (in_data) begin
                // first digit of a byte is its high nibble
                for (int i = 0; i < NumNib; i++) begin
                  if (nib_k == PosW'(i ^ 1)) begin
                    data_d[4*i +: 4] = data_q[4*i +: 4] | digit;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      kind_q   <= KIND_UNDECIDED;
      ident_q  <= '0;
      length_q <= '0;
      data_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      kind_q   <= kind_d;
      ident_q  <= ident_d;
      length_q <= length_d;
      data_q   <= data_d;
    end
  end

  always_comb begin
    frame_o        = '0;
    frame_o.ident  = ident_q;
    frame_o.length = length_q;
    frame_o.data   = FrameDataW'(data_q);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slcan_frame_parser_unit.sv =====
// Top level of the serial-line CAN frame parser: byte stream in, frame stream out.
//
// Slave side takes one received ASCII character per beat in s_axis_tdata_i.
// Lines of the form 't', three identifier hex digits, one length digit and
// data digit pairs, closed by carriage return, produce one beat on the
// master side carrying identifier, length digit and up to eight data bytes
// (byte 0 in the lowest byte). Lines holding 'z' and lines not starting with
// 't' produce nothing. Each character is absorbed in the cycle it is taken.
// The frame appears on m_axis in the cycle after the carriage return
// beat. Throughput: one character per cycle, limited only by the single
// output register. When the receiver stalls with a frame held, s_axis_tready_o
// drops until that frame is taken or taken in the same cycle.
// Reset clears the line state and empties the output register; the first
// character after reset starts a new line.
`default_nettype none

module slcan_frame_parser_unit #(
  parameter int unsigned MAX_DATA_BYTES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [79:0]      m_axis_tdata_o    // [11:0] frame_ident, [15:12] frame_length,
                                             // [79:16] frame_data
);
  import slcan_pkg::*;

  logic   take;
  logic   frame_done;
  frame_t frame;
  frame_t out_q;
  logic   out_valid_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  slcan_line_acc #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_line_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_i      (s_axis_tdata_i),
    .frame_o     (frame),
    .frame_done_o(frame_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the frame until the next one replaces it
  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      out_q <= frame;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire
